>>> src/bpd_pkg.sv
// Shared types and constants for the button press duration classifier.
// No dependencies; used by every module of the block.
package bpd_pkg;

  localparam int unsigned MASK_W    = 16;
  localparam int unsigned TS_W      = 48;
  localparam int unsigned THR_W     = 32;
  localparam int unsigned BTN_NUM_W = 5;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd500000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 4'd0,
    CFG_ENABLE    = 4'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [BTN_NUM_W-1:0] button_number;
    logic                 is_long;
    logic                 last_event;
  } evt_t;

endpackage

>>> src/bpd_front.sv
// Front end: accepts scans, tracks press start times, classifies each release.
// Emits one release word per cycle while the queue has room. Depends on bpd_pkg.
module bpd_front #(
  parameter int unsigned BUTTON_COUNT = 16,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bpd_pkg::MASK_W-1:0]      pressed_mask_i,
  input  logic [bpd_pkg::TS_W-1:0]        timestamp_us_i,
  input  logic [bpd_pkg::THR_W-1:0]       threshold_i,
  input  logic                            enabled_i,
  output logic                            evt_valid_o,
  input  logic                            evt_stall_i,
  output bpd_pkg::evt_t                   evt_o
);

  localparam int unsigned IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int unsigned CMP_W = (TIME_BITS > bpd_pkg::THR_W) ? TIME_BITS : bpd_pkg::THR_W;

  logic [BUTTON_COUNT-1:0] prev_q, prev_d;
  logic [BUTTON_COUNT-1:0] rem_q, rem_d;
  logic [TIME_BITS-1:0]    now_q;
  logic [TIME_BITS-1:0]    start_q [BUTTON_COUNT];

  logic [BUTTON_COUNT-1:0] cur, rise, fall, rem_next;
  logic [TIME_BITS-1:0]    ts, dur;
  logic [IDX_W-1:0]        idx;
  logic                    take, adv;

  assign cur  = BUTTON_COUNT'(pressed_mask_i);
  assign ts   = TIME_BITS'(timestamp_us_i);
  assign rise = cur & ~prev_q;
  assign fall = ~cur & prev_q;

  assign in_stall_o = |rem_q;
  assign take       = in_valid_i & ~in_stall_o & enabled_i;

  // lowest pending release
  always_comb begin
    idx = '0;
    for (int b = BUTTON_COUNT - 1; b >= 0; b--) begin
      if (rem_q[b]) idx = IDX_W'(b);
    end
  end

  assign rem_next    = rem_q & (rem_q - BUTTON_COUNT'(1));
  assign evt_valid_o = |rem_q;
  assign adv         = evt_valid_o & ~evt_stall_i;
  assign dur         = now_q - start_q[idx];

  always_comb begin
    evt_o.button_number = bpd_pkg::BTN_NUM_W'(idx) + bpd_pkg::BTN_NUM_W'(1);
    evt_o.is_long       = CMP_W'(dur) > CMP_W'(threshold_i);
    evt_o.last_event    = ~|rem_next;
  end

  always_comb begin
    prev_d = prev_q;
    rem_d  = rem_q;
    if (take) begin
      prev_d = cur;
      rem_d  = fall;
    end else if (adv) begin
      rem_d = rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      rem_q  <= '0;
    end else begin
      prev_q <= prev_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) now_q <= ts;
    for (int b = 0; b < BUTTON_COUNT; b++) begin
      if (take && rise[b]) start_q[b] <= ts;
    end
  end

endmodule

>>> src/bpd_queue.sv
// Small FIFO of release words between front end and output stage.
// Depends on bpd_pkg for the word type and depth.
module bpd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  bpd_pkg::evt_t wdata_i,
  input  logic          pop_i,
  output logic          nempty_o,
  output bpd_pkg::evt_t rdata_o
);

  localparam int unsigned CNT_W = bpd_pkg::QPTR_W + 1;

  bpd_pkg::evt_t             mem_q [bpd_pkg::QUEUE_DEPTH];
  logic [bpd_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       do_push, do_pop;

  assign full_o   = cnt_q == CNT_W'(bpd_pkg::QUEUE_DEPTH);
  assign nempty_o = cnt_q != '0;
  assign do_push  = push_i & ~full_o;
  assign do_pop   = pop_i & nempty_o;
  assign rdata_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + bpd_pkg::QPTR_W'(do_push);
    rd_ptr_d = rd_ptr_q + bpd_pkg::QPTR_W'(do_pop);
    cnt_d    = cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

>>> src/bpd_back.sv
// Output stage: drains the queue into a registered valid/stall result port.
// Depends on bpd_pkg for the word type.
module bpd_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_nempty_i,
  input  bpd_pkg::evt_t                   q_data_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bpd_pkg::BTN_NUM_W-1:0]   button_number_o,
  output logic                            long_press_o,
  output logic                            last_event_o
);

  logic          valid_q, valid_d;
  bpd_pkg::evt_t data_q;
  logic          load;

  assign load    = q_nempty_i & (~valid_q | ~out_stall_i);
  assign q_pop_o = load;

  always_comb begin
    valid_d = valid_q;
    if (load) valid_d = 1'b1;
    else if (!out_stall_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) data_q <= q_data_i;
  end

  assign out_valid_o     = valid_q;
  assign button_number_o = data_q.button_number;
  assign long_press_o    = data_q.is_long;
  assign last_event_o    = data_q.last_event;

endmodule

>>> src/button_press_duration_classifier_top.sv
// Top level of the button press duration classifier: config registers,
// front end, release queue and output stage. Depends on bpd_pkg and submodules.
//
// Each accepted scan updates the press start times at once; the front end then
// classifies one released button per cycle while the queue is not full (one
// duration subtract and threshold compare); a scan with releases holds off the
// next scan until all are classified, longer under output stalls once the queue
// fills; a scan without releases holds nothing off. Words wait in a four-deep
// queue and leave through a registered output, lowest button first, with
// last_event set on the final word of a scan. Scans taken while events are
// disabled are consumed with no effect. Configuration writes are always ready.
module button_press_duration_classifier_top #(
  parameter int unsigned BUTTON_COUNT = 16,
  parameter int unsigned TIME_BITS    = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bpd_pkg::MASK_W-1:0]      pressed_mask_i,
  input  logic [bpd_pkg::TS_W-1:0]        timestamp_us_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bpd_pkg::BTN_NUM_W-1:0]   button_number_o,
  output logic                            long_press_o,
  output logic                            last_event_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bpd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bpd_pkg::CFG_DAT_W-1:0]   cfg_wdata_i
);

  logic [bpd_pkg::THR_W-1:0] thr_q, thr_d;
  logic                      en_q, en_d;
  logic                      cfg_we;

  logic          evt_valid, q_full, q_nempty, q_pop;
  bpd_pkg::evt_t evt, q_data;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    thr_d = thr_q;
    en_d  = en_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        bpd_pkg::CFG_THRESHOLD: thr_d = bpd_pkg::THR_W'(cfg_wdata_i);
        bpd_pkg::CFG_ENABLE:    en_d  = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= bpd_pkg::THRESHOLD_RESET;
      en_q  <= 1'b0;
    end else begin
      thr_q <= thr_d;
      en_q  <= en_d;
    end
  end

  bpd_front #(
    .BUTTON_COUNT (BUTTON_COUNT),
    .TIME_BITS    (TIME_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pressed_mask_i (pressed_mask_i),
    .timestamp_us_i (timestamp_us_i),
    .threshold_i    (thr_q),
    .enabled_i      (en_q),
    .evt_valid_o    (evt_valid),
    .evt_stall_i    (q_full),
    .evt_o          (evt)
  );

  bpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (evt_valid),
    .full_o   (q_full),
    .wdata_i  (evt),
    .pop_i    (q_pop),
    .nempty_o (q_nempty),
    .rdata_o  (q_data)
  );

  bpd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_nempty_i      (q_nempty),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .button_number_o (button_number_o),
    .long_press_o    (long_press_o),
    .last_event_o    (last_event_o)
  );

endmodule

>>> sim/button_press_duration_classifier_top_tb.sv
// Testbench for button_press_duration_classifier_top: scans driven from a queue,
// release words predicted per scan and checked in order against the DUT.
// Depends on bpd_pkg and the RTL of the block.
module button_press_duration_classifier_top_tb;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned RAND_PHASES = 5;
  localparam int unsigned PHASE_SCANS = 51;

  typedef struct {
    logic [bpd_pkg::MASK_W-1:0] mask;
    logic [bpd_pkg::TS_W-1:0]   ts;
    bit                         drain;
  } scan_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic [bpd_pkg::MASK_W-1:0]    pressed_mask_i = '0;
  logic [bpd_pkg::TS_W-1:0]      timestamp_us_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [bpd_pkg::BTN_NUM_W-1:0] button_number_o;
  logic                          long_press_o;
  logic                          last_event_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [bpd_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [bpd_pkg::CFG_DAT_W-1:0] cfg_wdata_i = '0;

  // predictor state
  logic [bpd_pkg::THR_W-1:0]  long_thr = bpd_pkg::THRESHOLD_RESET;
  logic                       events_on = 1'b0;
  logic [bpd_pkg::MASK_W-1:0] held_mask = '0;
  logic [bpd_pkg::TS_W-1:0]   press_start [bpd_pkg::MASK_W];

  scan_t          pending_scans [$];
  bpd_pkg::evt_t  release_exp_q [$];

  int unsigned   cycle_cnt = 0;
  int unsigned   scans_pushed = 0;
  int unsigned   scans_taken = 0;
  int unsigned   words_checked = 0;
  int unsigned   mismatch_cnt = 0;
  int unsigned   send_gap = 0;
  int unsigned   stall_left = 0;
  bit            calm = 1'b0;
  scan_t         next_scan;
  bpd_pkg::evt_t want;

  logic [bpd_pkg::MASK_W-1:0] gen_mask = '0;
  logic [bpd_pkg::TS_W-1:0]   gen_ts = '0;

  button_press_duration_classifier_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pressed_mask_i  (pressed_mask_i),
    .timestamp_us_i  (timestamp_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .button_number_o (button_number_o),
    .long_press_o    (long_press_o),
    .last_event_o    (last_event_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("MISMATCH cycle %0d: %s", cycle_cnt, what);
    mismatch_cnt++;
  endtask

  function automatic void classify_releases(input logic [bpd_pkg::MASK_W-1:0] mask,
                                            input logic [bpd_pkg::TS_W-1:0] ts);
    bpd_pkg::evt_t            words [$];
    bpd_pkg::evt_t            w;
    logic [bpd_pkg::TS_W-1:0] dur;
    if (!events_on) return;
    for (int b = 0; b < bpd_pkg::MASK_W; b++) begin
      if (mask[b] && !held_mask[b]) begin
        press_start[b] = ts;
      end else if (!mask[b] && held_mask[b]) begin
        dur = ts - press_start[b];
        w.button_number = bpd_pkg::BTN_NUM_W'(b + 1);
        w.is_long       = (dur > bpd_pkg::TS_W'(long_thr));
        w.last_event    = 1'b0;
        words.push_back(w);
      end
    end
    if (words.size() > 0) words[words.size()-1].last_event = 1'b1;
    foreach (words[i]) release_exp_q.push_back(words[i]);
    held_mask = mask;
  endfunction

  // scan driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      pressed_mask_i <= '0;
      timestamp_us_i <= '0;
      send_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        classify_releases(pressed_mask_i, timestamp_us_i);
        scans_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 5);
          in_valid_i <= 1'b0;
        end else if (pending_scans.size() > 0 &&
                     !(pending_scans[0].drain && release_exp_q.size() != 0)) begin
          next_scan = pending_scans.pop_front();
          in_valid_i     <= 1'b1;
          pressed_mask_i <= next_scan.mask;
          timestamp_us_i <= next_scan.ts;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // release word stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // release word monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (release_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word for button %0d", button_number_o));
      end else begin
        want = release_exp_q.pop_front();
        if (button_number_o !== want.button_number)
          report_mismatch($sformatf("button_number %0d, want %0d",
                                    button_number_o, want.button_number));
        if (long_press_o !== want.is_long)
          report_mismatch($sformatf("long_press %0b, want %0b (button %0d)",
                                    long_press_o, want.is_long, want.button_number));
        if (last_event_o !== want.last_event)
          report_mismatch($sformatf("last_event %0b, want %0b (button %0d)",
                                    last_event_o, want.last_event, want.button_number));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout: %0d words still pending", release_exp_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic push_scan(input logic [bpd_pkg::MASK_W-1:0] mask,
                           input logic [bpd_pkg::TS_W-1:0] ts,
                           input bit drain);
    scan_t s;
    s.mask  = mask;
    s.ts    = ts;
    s.drain = drain;
    pending_scans.push_back(s);
    scans_pushed++;
    gen_mask = mask;
    gen_ts   = ts;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (scans_taken != scans_pushed || release_exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [bpd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpd_pkg::CFG_DAT_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (bpd_pkg::cfg_reg_e'(idx))
      bpd_pkg::CFG_THRESHOLD: long_thr = val;
      bpd_pkg::CFG_ENABLE:    events_on = val[0];
      default: ;
    endcase
  endtask

  task automatic push_random_scan(input bit drain);
    logic [bpd_pkg::TS_W-1:0]   step;
    logic [bpd_pkg::MASK_W-1:0] mask;
    case ($urandom_range(0, 9))
      0, 1, 2: step = bpd_pkg::TS_W'($urandom_range(0, 3000));
      3, 4, 5: step = bpd_pkg::TS_W'(long_thr) - bpd_pkg::TS_W'(2)
                      + bpd_pkg::TS_W'($urandom_range(0, 4));
      6, 7:    step = bpd_pkg::TS_W'($urandom);
      8:       step = {16'($urandom_range(0, 65535)), 32'($urandom)};
      default: step = '0;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: mask = gen_mask ^ (bpd_pkg::MASK_W'(1)
                                     << $urandom_range(0, bpd_pkg::MASK_W - 1));
      4, 5:       mask = gen_mask ^ (bpd_pkg::MASK_W'(1)
                                     << $urandom_range(0, bpd_pkg::MASK_W - 1))
                                  ^ (bpd_pkg::MASK_W'(1)
                                     << $urandom_range(0, bpd_pkg::MASK_W - 1));
      6, 7:       mask = gen_mask ^ bpd_pkg::MASK_W'($urandom);
      8:          mask = bpd_pkg::MASK_W'($urandom);
      default:    mask = $urandom_range(0, 1) ? '1 : '0;
    endcase
    push_scan(mask, gen_ts + step, drain);
  endtask

  initial begin
    logic [bpd_pkg::CFG_DAT_W-1:0] phase_thr [RAND_PHASES];
    for (int b = 0; b < bpd_pkg::MASK_W; b++) press_start[b] = '0;
    phase_thr[0] = 32'd1000;
    phase_thr[1] = bpd_pkg::THRESHOLD_RESET;
    phase_thr[2] = 32'd0;
    phase_thr[3] = 32'hFFFF_FFFF;
    phase_thr[4] = $urandom;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // events disabled out of reset: scans are dropped
    push_scan(16'h00FF, 48'd10, 1'b0);
    push_scan(16'h0000, 48'd20, 1'b0);
    wait_idle();
    cfg_write(bpd_pkg::CFG_ENABLE, 32'd1);
    cfg_write(bpd_pkg::CFG_THRESHOLD, bpd_pkg::THRESHOLD_RESET);

    push_scan(16'h0001, 48'd100, 1'b0);
    push_scan(16'h0000, 48'd500100, 1'b0);             // duration equals threshold
    push_scan(16'h0001, 48'd600000, 1'b0);
    push_scan(16'h0000, 48'd1100001, 1'b0);            // one above threshold
    push_scan(16'hFFFF, 48'hFFFF_FFFF_FFF0, 1'b0);
    push_scan(16'h0000, 48'd5, 1'b0);                  // all released across wrap
    push_scan(16'hFFFF, 48'd0, 1'b0);
    push_scan(16'hAAAA, 48'd400000, 1'b0);
    push_scan(16'h5555, 48'd1000000, 1'b0);            // falls and rises together
    push_scan(16'h5555, 48'd1000007, 1'b0);            // no change
    push_scan(16'h0000, 48'hFFFF_FFFF_FFFF, 1'b0);
    push_scan(16'h8000, 48'd3, 1'b0);
    push_scan(16'h0000, 48'd3, 1'b0);
    wait_idle();

    // unmapped index
    cfg_write(bpd_pkg::CFG_IDX_W'(bpd_pkg::CFG_ENABLE + 1 + $urandom_range(0, 13)), $urandom);
    cfg_write(bpd_pkg::CFG_THRESHOLD, 32'd0);
    push_scan(16'h0003, 48'h7FFF_0000_0000, 1'b0);
    push_scan(16'h0002, 48'h7FFF_0000_0000, 1'b0);
    push_scan(16'h0000, 48'h7FFF_0000_0001, 1'b0);
    wait_idle();

    cfg_write(bpd_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
    push_scan(16'h0101, 48'h0000_1000_0000, 1'b0);
    push_scan(16'h0100, 48'h0000_1000_0000 + 48'hFFFF_FFFF, 1'b0);
    push_scan(16'h0000, 48'h0000_1000_0000 + 48'h1_0000_0000, 1'b0);
    push_scan(16'h00F0, 48'h0000_2000_0000, 1'b0);
    wait_idle();

    // disabled in the middle of a press: state must survive
    cfg_write(bpd_pkg::CFG_ENABLE, 32'd0);
    push_scan(16'h0000, 48'h0000_2000_0010, 1'b0);
    push_scan(16'hFFFF, 48'h0000_2000_0020, 1'b0);
    wait_idle();
    cfg_write(bpd_pkg::CFG_ENABLE, 32'd1);
    push_scan(16'h0000, 48'h0000_2000_0064, 1'b0);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      cfg_write(bpd_pkg::CFG_THRESHOLD, phase_thr[p]);
      if (p == RAND_PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_SCANS; n++)
        push_random_scan(n == PHASE_SCANS / 2 || $urandom_range(0, 39) == 0);
      wait_idle();
    end

    $display("covered %0d scans and %0d release words over thresholds 0, 1000,",
             scans_taken, words_checked);
    $display("reset value, maximum and random, with wrap and disabled scans");
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/bpd_pkg.sv
src/bpd_front.sv
src/bpd_queue.sv
src/bpd_back.sv
src/button_press_duration_classifier_top.sv
sim/button_press_duration_classifier_top_tb.sv
